@@ rtl/rgbpb_pkg.sv @@
// Shared types and constants for the RGB pixel blend block.
`default_nettype none
package rgbpb_pkg;

  // Channel and configuration widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned ScaleW = ChanW + 1;
  localparam int unsigned ProdW  = ChanW + ScaleW;

  // Configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  // Blend modes
  localparam logic [ModeW-1:0] MODE_ADD       = 3'd0;
  localparam logic [ModeW-1:0] MODE_MULTIPLY  = 3'd1;
  localparam logic [ModeW-1:0] MODE_SCREEN    = 3'd2;
  localparam logic [ModeW-1:0] MODE_OVERLAY   = 3'd3;
  localparam logic [ModeW-1:0] MODE_LIGHTEN   = 3'd4;
  localparam logic [ModeW-1:0] MODE_DARKEN    = 3'd5;
  localparam logic [ModeW-1:0] MODE_ALPHA     = 3'd6;
  localparam logic [ModeW-1:0] MODE_OVERWRITE = 3'd7;

  // Reset values of the configuration registers
  localparam logic [ModeW-1:0] MODE_RESET  = MODE_OVERWRITE;
  localparam logic [ChanW-1:0] ALPHA_RESET = 8'hFF;

  // Load enables for the three pipeline stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

endpackage
`default_nettype wire

@@ rtl/rgbpb_ctrl.sv @@
// Valid tracking and stall control for the three-stage blend pipeline.
`default_nettype none
module rgbpb_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rgbpb_pkg::stage_en_t    en_o
);

  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  rgbpb_pkg::stage_en_t en;

  // A stage loads when empty or when its word moves on
  always_comb begin
    en.en3 = !v3_q || out_ready_i;
    en.en2 = !v2_q || en.en3;
    en.en1 = !v1_q || en.en2;
  end

  always_comb begin
    v1_d = en.en1 ? in_valid_i : v1_q;
    v2_d = en.en2 ? v1_q : v2_q;
    v3_d = en.en3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en.en1;
  assign out_valid_o = v3_q;

  // An accepted word occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted word not in stage 1");

  // A stalled output word is kept
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_ready_i |=> v3_q)
    else $error("stalled output word dropped");

  // Stage 1 word moves to stage 2 when it advances
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en.en2 |=> v2_q)
    else $error("stage 1 word lost");

  // Input is refused only when every stage is full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input stalled with room in pipeline");

endmodule
`default_nettype wire

@@ rtl/rgbpb_chan.sv @@
// Three-stage datapath blending one color channel.
`default_nettype none
module rgbpb_chan (
  input  wire logic                               clk_i,
  input  wire rgbpb_pkg::stage_en_t               en_i,
  input  wire logic [rgbpb_pkg::ModeW-1:0]        mode_i,
  input  wire logic [rgbpb_pkg::ChanW-1:0]        alpha_i,
  input  wire logic [rgbpb_pkg::ChanW-1:0]        base_i,
  input  wire logic [rgbpb_pkg::ChanW-1:0]        top_i,
  output logic      [rgbpb_pkg::ChanW-1:0]        mix_o
);

  localparam int unsigned W  = rgbpb_pkg::ChanW;
  localparam int unsigned SW = rgbpb_pkg::ScaleW;
  localparam int unsigned PW = rgbpb_pkg::ProdW;

  // Stage 1: scale top by opacity (exact identity at full opacity)
  logic [PW-1:0] top_prod;
  logic [W-1:0]  b1_q, t1_q;

  assign top_prod = PW'(top_i) * PW'({1'b0, alpha_i} + SW'(1));

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      b1_q <= base_i;
      t1_q <= top_prod[PW-2:W];
    end
  end

  // Stage 2: one shared 8x9 multiplier, operands chosen by mode
  logic [W-1:0]  op_a;
  logic [SW-1:0] op_b;
  logic [PW-1:0] prod;
  logic [W-1:0]  b2_q, t2_q, p2_q;

  always_comb begin
    case (mode_i)
      rgbpb_pkg::MODE_SCREEN: begin
        op_a = ~b1_q;
        op_b = SW'(256) - {1'b0, t1_q};
      end
      rgbpb_pkg::MODE_OVERLAY: begin
        if (b1_q[W-1]) begin
          op_a = ~b1_q;
          op_b = SW'(256) - {1'b0, t1_q};
        end else begin
          op_a = {b1_q[W-2:0], 1'b0};
          op_b = {1'b0, t1_q} + SW'(1);
        end
      end
      rgbpb_pkg::MODE_ALPHA: begin
        op_a = b1_q;
        op_b = SW'(256) - {1'b0, alpha_i};
      end
      default: begin
        op_a = b1_q;
        op_b = {1'b0, t1_q} + SW'(1);
      end
    endcase
  end

  assign prod = PW'(op_a) * PW'(op_b);

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      b2_q <= b1_q;
      t2_q <= t1_q;
      p2_q <= prod[PW-2:W];
    end
  end

  // Stage 3: final combine and saturation
  logic [W:0]   add_bt, add_tp;
  logic [W-1:0] sat_bt, sat_tp, mix_d, mix_q;

  assign add_bt = {1'b0, b2_q} + {1'b0, t2_q};
  assign add_tp = {1'b0, t2_q} + {1'b0, p2_q};
  assign sat_bt = add_bt[W] ? {W{1'b1}} : add_bt[W-1:0];
  assign sat_tp = add_tp[W] ? {W{1'b1}} : add_tp[W-1:0];

  always_comb begin
    if (alpha_i == '0) begin
      mix_d = b2_q;
    end else begin
      case (mode_i)
        rgbpb_pkg::MODE_ADD:      mix_d = sat_bt;
        rgbpb_pkg::MODE_MULTIPLY: mix_d = p2_q;
        rgbpb_pkg::MODE_SCREEN:   mix_d = ~p2_q;
        rgbpb_pkg::MODE_OVERLAY:  mix_d = b2_q[W-1] ? ~p2_q : p2_q;
        rgbpb_pkg::MODE_LIGHTEN:  mix_d = (b2_q > t2_q) ? b2_q : t2_q;
        rgbpb_pkg::MODE_DARKEN:   mix_d = (b2_q < t2_q) ? b2_q : t2_q;
        rgbpb_pkg::MODE_ALPHA:    mix_d = sat_tp;
        default:                  mix_d = t2_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule
`default_nettype wire

@@ rtl/rgb_pixel_blend.sv @@
// Top level of the RGB888 layer blend block.
`default_nettype none
// Blends a top RGB888 pixel onto a base pixel using the mode and opacity held in
// two configuration registers (index 0: mode, index 1: opacity). Each pixel
// passes through three register stages (opacity scaling, one shared 8x9
// multiply per channel, final combine into the output register), and a result
// is offered on the output once its word reaches the output register. One
// word is taken every cycle while the output side keeps up. Write
// configuration only while the pipeline is empty.
module rgb_pixel_blend (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] base_red_i,
  input  wire logic [7:0] base_green_i,
  input  wire logic [7:0] base_blue_i,
  input  wire logic [7:0] top_red_i,
  input  wire logic [7:0] top_green_i,
  input  wire logic [7:0] top_blue_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      mix_red_o,
  output logic [7:0]      mix_green_o,
  output logic [7:0]      mix_blue_o
);

  logic [rgbpb_pkg::ModeW-1:0] mode_q, mode_d;
  logic [rgbpb_pkg::ChanW-1:0] alpha_q, alpha_d;
  rgbpb_pkg::stage_en_t        en;

  // Configuration registers
  always_comb begin
    mode_d  = mode_q;
    alpha_d = alpha_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbpb_pkg::REG_MODE:  mode_d  = cfg_data_i[rgbpb_pkg::ModeW-1:0];
        rgbpb_pkg::REG_ALPHA: alpha_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rgbpb_pkg::MODE_RESET;
      alpha_q <= rgbpb_pkg::ALPHA_RESET;
    end else begin
      mode_q  <= mode_d;
      alpha_q <= alpha_d;
    end
  end

  // Pipeline control
  rgbpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .en_o        (en)
  );

  // One datapath per channel
  rgbpb_chan u_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .mode_i  (mode_q),
    .alpha_i (alpha_q),
    .base_i  (base_red_i),
    .top_i   (top_red_i),
    .mix_o   (mix_red_o)
  );

  rgbpb_chan u_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .mode_i  (mode_q),
    .alpha_i (alpha_q),
    .base_i  (base_green_i),
    .top_i   (top_green_i),
    .mix_o   (mix_green_o)
  );

  rgbpb_chan u_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .mode_i  (mode_q),
    .alpha_i (alpha_q),
    .base_i  (base_blue_i),
    .top_i   (top_blue_i),
    .mix_o   (mix_blue_o)
  );

endmodule
`default_nettype wire
